// ===== hdl/gspt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gspt_pkg
// shared types and codes of the grouped source pool table
// ---------------------------------------------------------------------------
package gspt_pkg;

  localparam int KEY_W       = 16;
  localparam int ENTRIES_DEF = 16;

  // request codes
  localparam logic [2:0] REQ_ADD      = 3'd0;
  localparam logic [2:0] REQ_RELEASE  = 3'd1;
  localparam logic [2:0] REQ_DELETE   = 3'd2;
  localparam logic [2:0] REQ_SET_USE  = 3'd3;
  localparam logic [2:0] REQ_ALLOC    = 3'd4;
  localparam logic [2:0] REQ_HAS_FREE = 3'd5;
  localparam logic [2:0] REQ_LIST     = 3'd6;
  localparam logic [2:0] REQ_UNUSED   = 3'd7;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // which condition marks a cell as a hit
  typedef enum logic [2:0] {
    HIT_KEY  = 3'd0,  // valid and key matches
    HIT_FREE = 3'd1,  // valid, group matches, not in use
    HIT_PEND = 3'd2,  // pending mark set
    HIT_GRP  = 3'd3,  // valid and group matches
    HIT_REL  = 3'd4   // valid, group matches, in use
  } hit_sel_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] group;
    logic             in_use;
    logic             pend;
  } entry_t;

  // first-hit chain running from cell 0 upwards
  typedef struct packed {
    logic             seen;
    logic             more;
    logic [KEY_W-1:0] key;
    logic             in_use;
  } chain_t;

  // command broadcast to every cell
  typedef struct packed {
    hit_sel_t         sel;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] group;
    logic             insert;
    logic             write_grp;
    logic             write_use;
    logic             use_val;
    logic             remove;
    logic             clear_pend;
    logic             load_pend;
  } act_t;

endpackage

// ===== hdl/gspt_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gspt_cell
// one table slot: holds an entry, takes part in the first-hit chain and
// shifts to or from its neighbours on insert and remove
// ---------------------------------------------------------------------------
module gspt_cell
  import gspt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  act_t   act,
  input  entry_t left_ent,
  input  entry_t right_ent,
  input  logic   ge_left,
  output logic   ge,
  input  chain_t chain_in,
  output chain_t chain_out,
  output entry_t ent
);

  entry_t ent_next;
  logic   hit;
  logic   first;

  always_comb begin
    case (act.sel)
      HIT_KEY:  hit = ent.valid && (ent.key == act.key);
      HIT_FREE: hit = ent.valid && (ent.group == act.group) && !ent.in_use;
      HIT_PEND: hit = ent.valid && ent.pend;
      HIT_GRP:  hit = ent.valid && (ent.group == act.group);
      HIT_REL:  hit = ent.valid && (ent.group == act.group) && ent.in_use;
      default:  hit = 1'b0;
    endcase
  end

  assign first = hit && !chain_in.seen;
  // insertion point lies at or below this slot
  assign ge    = !ent.valid || (ent.key > act.key);

  always_comb begin
    chain_out.seen   = chain_in.seen | hit;
    chain_out.more   = chain_in.more | (hit & chain_in.seen);
    chain_out.key    = chain_in.key | (first ? ent.key : '0);
    chain_out.in_use = chain_in.in_use | (first & ent.in_use);
  end

  always_comb begin
    ent_next = ent;
    if (act.insert) begin
      if (ge_left) begin
        ent_next      = left_ent;
        ent_next.pend = 1'b0;
      end else if (ge) begin
        ent_next.valid  = 1'b1;
        ent_next.key    = act.key;
        ent_next.group  = act.group;
        ent_next.in_use = 1'b0;
        ent_next.pend   = 1'b0;
      end
    end else if (act.remove) begin
      if (chain_out.seen) begin
        ent_next = right_ent;
      end
    end else begin
      if (first && act.write_grp) begin
        ent_next.group = act.group;
      end
      if (first && act.write_use) begin
        ent_next.in_use = act.use_val;
      end
      if (first && act.clear_pend) begin
        ent_next.pend = 1'b0;
      end
      if (act.load_pend) begin
        ent_next.pend = hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent.key    <= ent_next.key;
    ent.group  <= ent_next.group;
    ent.in_use <= ent_next.in_use;
    if (rst) begin
      ent.valid <= 1'b0;
      ent.pend  <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
      ent.pend  <= ent_next.pend;
    end
  end

endmodule

// ===== hdl/grouped_source_pool_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grouped_source_pool_table
// sorted table of sources with group and in-use mark, built as a cell row
// ---------------------------------------------------------------------------
// The table is a row of ENTRIES cells, each holding one source; valid entries
// sit at the low end in ascending key order. Every request passes through an
// evaluate cycle (a first-hit chain runs along the row and its summary is
// registered) and an apply cycle (the row inserts, removes or rewrites in one
// step, shifting cells taking data from their left or right neighbour), then the
// result waits in the output register. Single-result requests pass these
// steps once; release and list first pass a marking state that sets pending
// marks, then repeat them for each result emitted. A new request is taken
// once the last result of the previous one has been transferred.
module grouped_source_pool_table
  import gspt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       req_type,
  input  logic [KEY_W-1:0] src_key,
  input  logic [KEY_W-1:0] group_id,
  input  logic             use_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [KEY_W-1:0] result_key,
  output logic             destroy_notice,
  output logic             last
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MARK  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_APPLY = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  // latched request
  logic [2:0]       req;
  logic [KEY_W-1:0] req_key;
  logic [KEY_W-1:0] req_grp;
  logic             req_use;

  // registered chain summary
  logic             sum_seen;
  logic             sum_more;
  logic [KEY_W-1:0] sum_key;
  logic             sum_use;
  logic             sum_full;

  act_t   act;
  entry_t cell_q [ENTRIES];
  chain_t chn    [ENTRIES+1];
  logic   ge_c   [ENTRIES+1];

  logic   multi;   // release or list: pending marks drive the scan
  logic   rel_more;

  logic             res_load;
  logic [1:0]       res_status;
  logic [KEY_W-1:0] res_key;
  logic             res_dn;
  logic             res_last;

  assign multi    = (req == REQ_RELEASE) || (req == REQ_LIST);
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  assign chn[0]  = '0;
  assign ge_c[0] = 1'b0;

  // row of cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t l_ent, r_ent;
    if (i == 0) begin : g_l0
      assign l_ent = '0;
    end else begin : g_ln
      assign l_ent = cell_q[i-1];
    end
    if (i == ENTRIES - 1) begin : g_rn
      assign r_ent = '0;
    end else begin : g_rm
      assign r_ent = cell_q[i+1];
    end
    gspt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .act       (act),
      .left_ent  (l_ent),
      .right_ent (r_ent),
      .ge_left   (ge_c[i]),
      .ge        (ge_c[i+1]),
      .chain_in  (chn[i]),
      .chain_out (chn[i+1]),
      .ent       (cell_q[i])
    );
  end

  // command to the row and the result of the apply cycle
  always_comb begin
    act        = '0;
    act.key    = req_key;
    act.group  = req_grp;
    act.sel    = HIT_KEY;
    res_load   = 1'b0;
    res_status = ST_MISS;
    res_key    = '0;
    res_dn     = 1'b0;
    res_last   = 1'b1;
    rel_more   = 1'b0;

    case (req)
      REQ_ALLOC, REQ_HAS_FREE: act.sel = HIT_FREE;
      REQ_RELEASE, REQ_LIST:   act.sel = HIT_PEND;
      default:                 act.sel = HIT_KEY;
    endcase

    case (state)
      S_MARK: begin
        act.sel       = (req == REQ_RELEASE) ? HIT_REL : HIT_GRP;
        act.load_pend = 1'b1;
      end
      S_APPLY: begin
        res_load = 1'b1;
        case (req)
          REQ_ADD: begin
            if (sum_seen) begin
              act.write_grp = 1'b1;
              act.write_use = 1'b1;
              act.use_val   = 1'b0;
              res_status    = ST_OK;
            end else if (sum_full) begin
              res_status = ST_FULL;
            end else begin
              act.insert = 1'b1;
              res_status = ST_OK;
            end
          end
          REQ_RELEASE, REQ_LIST: begin
            if (sum_seen) begin
              res_status = ST_OK;
              res_key    = sum_key;
              res_dn     = (req == REQ_RELEASE);
              res_last   = !sum_more;
              rel_more   = sum_more;
              if (req == REQ_RELEASE) begin
                act.remove = 1'b1;
              end else begin
                act.clear_pend = 1'b1;
              end
            end
          end
          REQ_DELETE: begin
            if (sum_seen && sum_use) begin
              act.remove = 1'b1;
              res_status = ST_OK;
            end
          end
          REQ_SET_USE: begin
            if (sum_seen) begin
              act.write_use = 1'b1;
              act.use_val   = req_use;
              res_status    = ST_OK;
            end
          end
          REQ_ALLOC: begin
            if (sum_seen) begin
              act.write_use = 1'b1;
              act.use_val   = 1'b1;
              res_status    = ST_OK;
              res_key       = sum_key;
            end
          end
          REQ_HAS_FREE: begin
            if (sum_seen) begin
              res_status = ST_OK;
            end
          end
          default: begin
            res_status = ST_MISS;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // sequencer
  logic more_q;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = ((req_type == REQ_RELEASE) || (req_type == REQ_LIST)) ? S_MARK
                                                                              : S_EVAL;
        end
      end
      S_MARK:  state_next = S_EVAL;
      S_EVAL:  state_next = S_APPLY;
      S_APPLY: state_next = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          state_next = (multi && more_q) ? S_EVAL : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request latch on input transfer
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req     <= req_type;
      req_key <= src_key;
      req_grp <= group_id;
      req_use <= use_value;
    end
  end

  // chain summary at the end of the row
  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      sum_seen <= chn[ENTRIES].seen;
      sum_more <= chn[ENTRIES].more;
      sum_key  <= chn[ENTRIES].key;
      sum_use  <= chn[ENTRIES].in_use;
      sum_full <= cell_q[ENTRIES-1].valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (res_load) begin
      status         <= res_status;
      result_key     <= res_key;
      destroy_notice <= res_dn;
      last           <= res_last;
      more_q         <= rel_more;
    end
  end

  // the block takes no request while a result is still held
  a_no_accept_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted while a result is held");

  // a destroy notice always comes from a successful release
  a_notice_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && destroy_notice) |-> (status == ST_OK))
    else $error("destroy notice with failing status");

  // a final result returns the block to idle once transferred
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> !in_stall)
    else $error("block not idle after final result");

  // a failing result is always the final one of its request
  a_miss_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> last)
    else $error("failing result is not final");

endmodule
